// ===== rtl/tts_pkg.sv =====
// Shared types, codes and constants for the two-tier sorted integer set.
package tts_pkg;

    localparam int SHORT_CAPACITY_DEF = 256;
    localparam int WIDE_CAPACITY_DEF  = 256;
    localparam int SHORT_W            = 16;
    localparam int WIDE_W             = 32;
    localparam int POS_W              = 10;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 11;

    localparam logic [9:0]  MAX_COUNT_RST    = 10'd512;
    localparam logic [10:0] MAX_BYTES_RST    = 11'd2047;
    localparam logic [7:0]  HEADER_BYTES_RST = 8'd32;

    typedef enum logic [2:0] {
        OP_FIND     = 3'd0,
        OP_ADD      = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_GET      = 3'd3,
        OP_ITER_RST = 3'd4,
        OP_NEXT     = 3'd5
    } op_e;

    typedef enum logic [1:0] {
        CFG_MAX_COUNT    = 2'd0,
        CFG_MAX_BYTES    = 2'd1,
        CFG_HEADER_BYTES = 2'd2
    } cfg_idx_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } state_e;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [63:0] value;
        logic [9:0]         item_index;
    } cmd_t;

    typedef struct packed {
        logic               hit;
        logic [9:0]         position;
        logic signed [31:0] value_out;
        logic [9:0]         total_count;
        logic               upgrade_advised;
        logic               store_full;
    } result_t;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

// ===== rtl/two_tier_sorted_int_set.sv =====
// Top level of the two-tier sorted integer set.
// Find, add, remove, iterator reset and next: accept, then one cell-chain update.
// Get by rank accepts, then walks the merged order once per cycle up to item_index.
// A new command may start in the cycle its result is strobed; the receiver cannot stall.
// Reset clears counts, iterator cursors, state, done and config; store stays undefined.
module two_tier_sorted_int_set #(
    parameter int SHORT_CAPACITY = tts_pkg::SHORT_CAPACITY_DEF,
    parameter int WIDE_CAPACITY  = tts_pkg::WIDE_CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tts_pkg::cmd_t                     cmd,
    output logic                              done,
    output tts_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SCNT_W = $clog2(SHORT_CAPACITY + 1);
    localparam int WCNT_W = $clog2(WIDE_CAPACITY + 1);
    localparam int SUM_W  = ((SCNT_W > WCNT_W) ? SCNT_W : WCNT_W) + 1;
    localparam int CMP_W  = ((SUM_W > 11) ? SUM_W : 11) + 3;

    tts_pkg::state_e    state_reg, state_next;
    logic [2:0]         op_reg;
    logic signed [63:0] key_reg;
    logic [9:0]         idx_reg;
    logic [SCNT_W-1:0]  sc_reg, sc_next, isp_reg, isp_next, ps_reg, ps_next;
    logic [WCNT_W-1:0]  wc_reg, wc_next, iwp_reg, iwp_next, pw_reg, pw_next;
    logic [9:0]         k_reg, k_next;
    logic [9:0]         max_count_reg;
    logic [10:0]        max_bytes_reg;
    logic [7:0]         header_reg;
    tts_pkg::result_t   res_reg, res_next;
    logic               done_reg, done_next;

    tts_pkg::cell_ctrl_t s_ctrl, w_ctrl;
    logic [SCNT_W-1:0]  s_rank, s_rd;
    logic [WCNT_W-1:0]  w_rank, w_rd;
    logic               s_found, w_found;
    logic [15:0]        s_head;
    logic [31:0]        w_head;
    logic signed [15:0] s_head_s;
    logic signed [31:0] w_head_s;
    logic signed [31:0] key32;
    logic               fits16, fits32;
    logic [CMP_W-1:0]   total_now, total_new, bytes_new;
    logic               get_ok, walk_last;
    logic               hs, hw, from_s;
    logic signed [31:0] pick_val;
    logic [SUM_W-1:0]   pos_full;

    assign key32     = key_reg[31:0];
    assign fits16    = (&key_reg[63:15]) || !(|key_reg[63:15]);
    assign fits32    = (&key_reg[63:31]) || !(|key_reg[63:31]);
    assign total_now = CMP_W'(sc_reg) + CMP_W'(wc_reg);
    assign get_ok    = CMP_W'(idx_reg) < total_now;
    assign walk_last = (k_reg == idx_reg);
    assign busy      = (state_reg != tts_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;

    assign s_rd = (state_reg == tts_pkg::ST_WALK) ? ps_reg : isp_reg;
    assign w_rd = (state_reg == tts_pkg::ST_WALK) ? pw_reg : iwp_reg;

    tts_chain #(.W(tts_pkg::SHORT_W), .DEPTH(SHORT_CAPACITY), .CNT_W(SCNT_W)) u_short (
        .clk    (clk),
        .ctrl   (s_ctrl),
        .key    (key32),
        .count  (sc_reg),
        .rd_pos (s_rd),
        .rank   (s_rank),
        .found  (s_found),
        .head   (s_head)
    );

    tts_chain #(.W(tts_pkg::WIDE_W), .DEPTH(WIDE_CAPACITY), .CNT_W(WCNT_W)) u_wide (
        .clk    (clk),
        .ctrl   (w_ctrl),
        .key    (key32),
        .count  (wc_reg),
        .rd_pos (w_rd),
        .rank   (w_rank),
        .found  (w_found),
        .head   (w_head)
    );

    assign s_head_s = s_head;
    assign w_head_s = w_head;
    assign hs       = s_rd < sc_reg;
    assign hw       = w_rd < wc_reg;
    assign from_s   = hs && (!hw || (32'(s_head_s) < w_head_s));
    assign pick_val = from_s ? 32'(s_head_s) : (hw ? w_head_s : 32'sd0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tts_pkg::ST_EXEC;
                end
            end
            tts_pkg::ST_EXEC:
            begin
                if (op_reg == tts_pkg::OP_GET && get_ok)
                begin
                    state_next = tts_pkg::ST_WALK;
                end
                else
                begin
                    state_next = tts_pkg::ST_IDLE;
                end
            end
            tts_pkg::ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = tts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_ctrl    = '0;
        w_ctrl    = '0;
        sc_next   = sc_reg;
        wc_next   = wc_reg;
        isp_next  = isp_reg;
        iwp_next  = iwp_reg;
        ps_next   = ps_reg;
        pw_next   = pw_reg;
        k_next    = k_reg;
        done_next = 1'b0;
        res_next  = '0;
        pos_full  = SUM_W'(s_rank) + SUM_W'(w_rank);
        if (state_reg == tts_pkg::ST_EXEC)
        begin
            done_next = 1'b1;
            case (op_reg)
                tts_pkg::OP_FIND:
                begin
                    if (fits16)
                    begin
                        res_next.hit      = s_found;
                        res_next.position = 10'(pos_full);
                    end
                    else if (fits32)
                    begin
                        res_next.hit      = w_found;
                        res_next.position = 10'(pos_full);
                    end
                    else if (!key_reg[63])
                    begin
                        res_next.position = 10'(total_now);
                    end
                end
                tts_pkg::OP_ADD:
                begin
                    if (fits16 && !s_found)
                    begin
                        if (sc_reg >= SCNT_W'(SHORT_CAPACITY))
                        begin
                            res_next.store_full = 1'b1;
                        end
                        else
                        begin
                            s_ctrl.ins   = 1'b1;
                            sc_next      = sc_reg + 1'b1;
                            res_next.hit = 1'b1;
                        end
                    end
                    else if (!fits16 && fits32 && !w_found)
                    begin
                        if (wc_reg >= WCNT_W'(WIDE_CAPACITY))
                        begin
                            res_next.store_full = 1'b1;
                        end
                        else
                        begin
                            w_ctrl.ins   = 1'b1;
                            wc_next      = wc_reg + 1'b1;
                            res_next.hit = 1'b1;
                        end
                    end
                end
                tts_pkg::OP_REMOVE:
                begin
                    if (fits16 && s_found)
                    begin
                        s_ctrl.del   = 1'b1;
                        sc_next      = sc_reg - 1'b1;
                        res_next.hit = 1'b1;
                    end
                    else if (!fits16 && fits32 && w_found)
                    begin
                        w_ctrl.del   = 1'b1;
                        wc_next      = wc_reg - 1'b1;
                        res_next.hit = 1'b1;
                    end
                end
                tts_pkg::OP_GET:
                begin
                    if (get_ok)
                    begin
                        done_next = 1'b0;
                        ps_next   = '0;
                        pw_next   = '0;
                        k_next    = '0;
                    end
                end
                tts_pkg::OP_ITER_RST:
                begin
                    isp_next = '0;
                    iwp_next = '0;
                end
                tts_pkg::OP_NEXT:
                begin
                    if (hs || hw)
                    begin
                        res_next.hit       = 1'b1;
                        res_next.value_out = pick_val;
                        if (from_s)
                        begin
                            isp_next = isp_reg + 1'b1;
                        end
                        else
                        begin
                            iwp_next = iwp_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    res_next.hit = 1'b0;
                end
            endcase
        end
        else if (state_reg == tts_pkg::ST_WALK)
        begin
            if (walk_last)
            begin
                done_next          = 1'b1;
                res_next.hit       = 1'b1;
                res_next.value_out = pick_val;
            end
            else
            begin
                k_next = k_reg + 1'b1;
                if (from_s)
                begin
                    ps_next = ps_reg + 1'b1;
                end
                else
                begin
                    pw_next = pw_reg + 1'b1;
                end
            end
        end
        total_new = CMP_W'(sc_next) + CMP_W'(wc_next);
        bytes_new = CMP_W'(header_reg) + (CMP_W'(sc_next) << 1) + (CMP_W'(wc_next) << 2);
        res_next.total_count     = 10'(total_new);
        res_next.upgrade_advised = !fits32 || (total_new >= CMP_W'(max_count_reg))
                                   || (bytes_new >= CMP_W'(max_bytes_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tts_pkg::ST_IDLE;
            sc_reg        <= '0;
            wc_reg        <= '0;
            isp_reg       <= '0;
            iwp_reg       <= '0;
            done_reg      <= 1'b0;
            max_count_reg <= tts_pkg::MAX_COUNT_RST;
            max_bytes_reg <= tts_pkg::MAX_BYTES_RST;
            header_reg    <= tts_pkg::HEADER_BYTES_RST;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            wc_reg    <= wc_next;
            isp_reg   <= isp_next;
            iwp_reg   <= iwp_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tts_pkg::CFG_MAX_COUNT:    max_count_reg <= cfg_data[9:0];
                    tts_pkg::CFG_MAX_BYTES:    max_bytes_reg <= cfg_data[10:0];
                    tts_pkg::CFG_HEADER_BYTES: header_reg    <= cfg_data[7:0];
                    default:                   header_reg    <= header_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= cmd.operation;
            key_reg <= cmd.value;
            idx_reg <= cmd.item_index;
        end
        ps_reg  <= ps_next;
        pw_reg  <= pw_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

endmodule

// ===== rtl/tts_cell.sv =====
// One storage cell of a sorted chain: holds an entry, compares it and shifts.
module tts_cell #(
    parameter int W = 16
) (
    input  logic                clk,
    input  tts_pkg::cell_ctrl_t ctrl,
    input  logic signed [31:0]  key,
    input  logic                in_use,
    input  logic                left_lt,
    input  logic [W-1:0]        left_val,
    input  logic [W-1:0]        right_val,
    output logic [W-1:0]        val,
    output logic                lt,
    output logic                eq
);

    logic [W-1:0]       val_reg;
    logic [W-1:0]       val_next;
    logic signed [W-1:0] sval;
    logic signed [31:0] ext_val;

    assign sval    = val_reg;
    assign ext_val = 32'(sval);
    assign lt      = in_use && (ext_val < key);
    assign eq      = in_use && (ext_val == key);
    assign val     = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins && !lt)
        begin
            val_next = left_lt ? key[W-1:0] : left_val;
        end
        else if (ctrl.del && !lt)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== rtl/tts_chain.sv =====
// A row of sorted cells with rank encoding, hit detection and a head read.
module tts_chain #(
    parameter int W     = 16,
    parameter int DEPTH = 256,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  tts_pkg::cell_ctrl_t ctrl,
    input  logic signed [31:0]  key,
    input  logic [CNT_W-1:0]    count,
    input  logic [CNT_W-1:0]    rd_pos,
    output logic [CNT_W-1:0]    rank,
    output logic                found,
    output logic [W-1:0]        head
);

    logic [W-1:0] vals [DEPTH];
    logic         lts  [DEPTH+1];
    logic [DEPTH-1:0] eqs;

    assign lts[DEPTH] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tts_cell #(.W(W)) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .key       (key),
            .in_use    (CNT_W'(i) < count),
            .left_lt   ((i == 0) ? 1'b1 : lts[(i == 0) ? 0 : i-1]),
            .left_val  (vals[(i == 0) ? 0 : i-1]),
            .right_val (vals[(i == DEPTH-1) ? i : i+1]),
            .val       (vals[i]),
            .lt        (lts[i]),
            .eq        (eqs[i])
        );
    end

    assign found = |eqs;

    always_comb
    begin
        rank = '0;
        head = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (lts[i] && !lts[i+1])
            begin
                rank = rank | CNT_W'(i + 1);
            end
            if (CNT_W'(i) == rd_pos)
            begin
                head = head | vals[i];
            end
        end
    end

endmodule

// ===== rtl/tts_checker.sv =====
// Port-level checker for the two-tier sorted integer set, bound to the top level.
module tts_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input tts_pkg::result_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result transfer without preceding work");

    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.store_full |-> !result.hit)
        else $error("store full reported together with hit");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

endmodule

bind two_tier_sorted_int_set tts_checker u_tts_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
